// ----- hdl/bfa_pkg.sv -----
// ----------------------------------------------------------------------------
// bfa_pkg
// Shared constants, types and controller/datapath handshake structs for the
// bitmap frame allocator.
// ----------------------------------------------------------------------------
package bfa_pkg;

  // Bitmap geometry
  localparam int MAX_FRAME_COUNT = 32768;
  localparam int MAP_WORDS       = (MAX_FRAME_COUNT + 31) / 32;
  localparam int WORD_AW         = $clog2(MAP_WORDS);
  localparam int WPTR_W          = $clog2(MAP_WORDS + 1);
  localparam int FRAME_IDX_W     = WORD_AW + 5;
  localparam int CNT_W           = $clog2(MAX_FRAME_COUNT + 1);

  // Field widths
  localparam int ADDR_W     = 32;
  localparam int CFG_W      = 32;
  localparam int KB_W       = 22;
  localparam int CNT_OUT_W  = 16;
  localparam int ADDR_OUT_W = 28;

  // Memory layout
  localparam logic [ADDR_W-1:0] MEM_BASE = 32'h0010_0000;
  localparam int FRAME_SHIFT     = 12;
  localparam int FALLBACK_FRAMES = (16 * 1024 * 1024 - 'h100000) / 4096;

  // Width of frame counts before capping
  localparam int SZ_W = ADDR_W - FRAME_SHIFT + 1;

  typedef enum logic [1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_INIT  = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    CFG_MEM_SIZE_VALID  = 2'd0,
    CFG_UPPER_MEM_KB    = 2'd1,
    CFG_KERNEL_END_ADDR = 2'd2,
    CFG_UNUSED          = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT_SIZE,
    ST_INIT,
    ST_SCAN,
    ST_FREE_CHK,
    ST_DONE
  } ctrl_state_t;

  // Controller -> datapath commands
  typedef struct packed {
    logic accept;
    logic init_start;
    logic init_size;
    logic init_write;
    logic scan_start;
    logic scan_check;
    logic free_start;
    logic free_check;
    logic resp_load;
  } dp_cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic no_free;
    logic free_in_range;
    logic scan_hit;
    logic scan_last;
    logic sweep_done;
    logic out_busy;
  } dp_stat_t;

endpackage

// ----- hdl/bfa_ctrl.sv -----
// ----------------------------------------------------------------------------
// bfa_ctrl
// Command sequencer: accepts a word, steps the datapath through init sweep,
// allocation scan or free read-modify-write, then hands off the result.
// ----------------------------------------------------------------------------
module bfa_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         cmd,
  input  bfa_pkg::dp_stat_t  stat,
  output bfa_pkg::dp_cmd_t   ctl
);
  import bfa_pkg::*;

  ctrl_state_t state, state_next;
  cmd_t        in_cmd;

  assign in_cmd = cmd_t'(cmd);

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          unique case (in_cmd)
            CMD_ALLOC: state_next = stat.no_free ? ST_DONE : ST_SCAN;
            CMD_FREE:  state_next = stat.free_in_range ? ST_FREE_CHK : ST_DONE;
            CMD_INIT:  state_next = ST_INIT_SIZE;
            default:   state_next = ST_DONE;
          endcase
        end
      end
      ST_INIT_SIZE: state_next = ST_INIT;
      ST_INIT: begin
        if (stat.sweep_done) state_next = ST_DONE;
      end
      ST_SCAN: begin
        if (stat.scan_hit || stat.scan_last) state_next = ST_DONE;
      end
      ST_FREE_CHK: state_next = ST_DONE;
      ST_DONE: begin
        if (!stat.out_busy) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Command outputs
  always_comb begin
    ctl      = '0;
    in_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready       = 1'b1;
        ctl.accept     = in_valid;
        ctl.init_start = in_valid && (in_cmd == CMD_INIT);
        ctl.scan_start = in_valid && (in_cmd == CMD_ALLOC) && !stat.no_free;
        ctl.free_start = in_valid && (in_cmd == CMD_FREE) && stat.free_in_range;
      end
      ST_INIT_SIZE: ctl.init_size = 1'b1;
      ST_INIT:      ctl.init_write = !stat.sweep_done;
      ST_SCAN:      ctl.scan_check = 1'b1;
      ST_FREE_CHK:  ctl.free_check = 1'b1;
      ST_DONE:      ctl.resp_load = !stat.out_busy;
      default: begin
        ctl      = '0;
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

// ----- hdl/bfa_dp.sv -----
// ----------------------------------------------------------------------------
// bfa_dp
// Allocator datapath: configuration registers, frame bitmap memory, counters,
// search hint, first-zero finder and the output register.
// ----------------------------------------------------------------------------
module bfa_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wr_en,
  input  logic [1:0]                        cfg_index,
  input  logic [bfa_pkg::CFG_W-1:0]         cfg_wdata,
  input  logic [bfa_pkg::ADDR_W-1:0]        frame_addr_in,
  input  bfa_pkg::dp_cmd_t                  ctl,
  output bfa_pkg::dp_stat_t                 stat,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [bfa_pkg::ADDR_OUT_W-1:0]    alloc_addr,
  output logic                              ok,
  output logic [bfa_pkg::CNT_OUT_W-1:0]     free_frames,
  output logic [bfa_pkg::CNT_OUT_W-1:0]     managed_frames
);
  import bfa_pkg::*;

  // Lowest set bit of a word
  function automatic logic [4:0] first_set(input logic [31:0] v);
    logic [4:0] pos;
    pos = '0;
    for (int i = 31; i >= 0; i--) begin
      if (v[i]) pos = 5'(i);
    end
    return pos;
  endfunction

  // Configuration
  logic                mem_size_valid;
  logic [KB_W-1:0]     upper_mem_kb;
  logic [ADDR_W-1:0]   kernel_end_addr;

  // Allocator state
  logic [CNT_W-1:0]       free_total;
  logic [CNT_W-1:0]       frame_total;
  logic [CNT_W-1:0]       kframes;
  logic [SZ_W-1:0]        kraw;
  logic [WPTR_W-1:0]      hint;
  logic [WPTR_W-1:0]      ptr;
  logic [FRAME_IDX_W-1:0] free_frame;
  logic                   res_ok;
  logic [ADDR_OUT_W-1:0]  res_addr;

  // Bitmap memory
  logic [31:0]        map_mem [MAP_WORDS];
  logic [31:0]        rd_data;
  logic [WORD_AW-1:0] rd_addr;
  logic [WORD_AW-1:0] wr_addr;
  logic [31:0]        wr_data;
  logic               wr_en;

  // Sizing
  logic [SZ_W-1:0]   size_raw;
  logic [SZ_W-1:0]   size_cap;
  logic [SZ_W-1:0]   kraw_calc;
  logic [ADDR_W-1:0] kern_off;
  logic [CNT_W-1:0]  kf_cap;
  logic [CNT_W:0]    tot_round;
  logic [WPTR_W-1:0] nwords;

  // Init sweep word
  logic [CNT_W:0] base_ext;
  logic [CNT_W:0] kf_ext;
  logic [CNT_W:0] kf_diff;
  logic [31:0]    init_word;

  // Scan
  logic [31:0]            inv;
  logic [4:0]             hit_pos;
  logic [FRAME_IDX_W-1:0] hit_frame;
  logic [ADDR_OUT_W-1:0]  hit_addr;
  logic [WPTR_W:0]        ptr_inc;

  // Free
  logic [ADDR_W-1:0]              addr_off;
  logic [ADDR_W-FRAME_SHIFT-1:0]  f_in;
  logic                           free_bit;
  logic [WORD_AW-1:0]             free_word;

  // Frame total and kernel reservation
  always_comb begin
    size_raw  = (mem_size_valid && upper_mem_kb != '0) ? SZ_W'(upper_mem_kb >> 2)
                                                        : SZ_W'(FALLBACK_FRAMES);
    size_cap  = (size_raw > SZ_W'(MAX_FRAME_COUNT)) ? SZ_W'(MAX_FRAME_COUNT) : size_raw;
    kern_off  = kernel_end_addr - MEM_BASE;
    kraw_calc = SZ_W'(kern_off >> FRAME_SHIFT) + SZ_W'(1);
    kf_cap    = (kraw > SZ_W'(frame_total)) ? frame_total : CNT_W'(kraw);
    tot_round = {1'b0, frame_total} + (CNT_W + 1)'(31);
    nwords    = WPTR_W'(tot_round >> 5);
  end

  // Word written by the init sweep: kernel frames set, rest clear
  always_comb begin
    base_ext = (CNT_W + 1)'({ptr, 5'b0});
    kf_ext   = {1'b0, kframes};
    kf_diff  = kf_ext - base_ext;
    if (kf_ext <= base_ext) begin
      init_word = '0;
    end else if (kf_diff >= (CNT_W + 1)'(32)) begin
      init_word = '1;
    end else begin
      init_word = ~(32'hFFFF_FFFF << kf_diff[4:0]);
    end
  end

  // First free frame in the word under scan
  always_comb begin
    inv       = ~rd_data;
    hit_pos   = first_set(inv);
    hit_frame = {ptr[WORD_AW-1:0], hit_pos};
    hit_addr  = ADDR_OUT_W'(MEM_BASE) + (ADDR_OUT_W'(hit_frame) << FRAME_SHIFT);
    ptr_inc   = (WPTR_W + 1)'(ptr) + (WPTR_W + 1)'(1);
  end

  // Free address decode
  always_comb begin
    addr_off  = frame_addr_in - MEM_BASE;
    f_in      = addr_off[ADDR_W-1:FRAME_SHIFT];
    free_bit  = rd_data[free_frame[4:0]];
    free_word = free_frame[FRAME_IDX_W-1:5];
  end

  // Status
  always_comb begin
    stat.no_free       = (free_total == '0);
    stat.free_in_range = (frame_addr_in >= MEM_BASE) &&
                         (SZ_W'(f_in) < SZ_W'(frame_total));
    stat.scan_hit      = (inv != '0) && (CNT_W'(hit_frame) < frame_total);
    stat.scan_last     = (ptr_inc >= (WPTR_W + 1)'(nwords));
    stat.sweep_done    = (ptr == nwords);
    stat.out_busy      = out_valid && !out_ready;
  end

  // Memory port select
  always_comb begin
    if (ctl.scan_start) begin
      rd_addr = hint[WORD_AW-1:0];
    end else if (ctl.free_start) begin
      rd_addr = f_in[FRAME_IDX_W-1:5];
    end else begin
      rd_addr = ptr_inc[WORD_AW-1:0];
    end

    wr_en   = 1'b0;
    wr_addr = ptr[WORD_AW-1:0];
    wr_data = init_word;
    if (ctl.init_write) begin
      wr_en = 1'b1;
    end else if (ctl.scan_check && stat.scan_hit) begin
      wr_en   = 1'b1;
      wr_data = rd_data | (32'h1 << hit_pos);
    end else if (ctl.free_check && free_bit) begin
      wr_en   = 1'b1;
      wr_addr = free_word;
      wr_data = rd_data & ~(32'h1 << free_frame[4:0]);
    end
  end

  // Bitmap memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      map_mem[wr_addr] <= wr_data;
    end
    rd_data <= map_mem[rd_addr];
  end

  // Configuration and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      mem_size_valid  <= 1'b1;
      upper_mem_kb    <= '0;
      kernel_end_addr <= MEM_BASE;
      free_total      <= '0;
      frame_total     <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_MEM_SIZE_VALID:  mem_size_valid  <= cfg_wdata[0];
          CFG_UPPER_MEM_KB:    upper_mem_kb    <= cfg_wdata[KB_W-1:0];
          CFG_KERNEL_END_ADDR: kernel_end_addr <= cfg_wdata[ADDR_W-1:0];
          default: ;
        endcase
      end
      if (ctl.init_start) frame_total <= CNT_W'(size_cap);
      if (ctl.init_size) free_total <= frame_total - kf_cap;
      if (ctl.scan_check && stat.scan_hit) free_total <= free_total - CNT_W'(1);
      if (ctl.free_check && free_bit) free_total <= free_total + CNT_W'(1);
      if (ctl.resp_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Working registers and result payload
  always_ff @(posedge clk) begin
    // init always reports ok
    if (ctl.accept) begin
      res_ok   <= ctl.init_start;
      res_addr <= '0;
    end
    if (ctl.init_start) begin
      kraw <= kraw_calc;
    end
    if (ctl.init_size) begin
      kframes <= kf_cap;
      hint    <= WPTR_W'(kf_cap >> 5);
      ptr     <= '0;
    end
    if (ctl.init_write) ptr <= WPTR_W'(ptr_inc);
    if (ctl.scan_start) ptr <= hint;
    if (ctl.scan_check) begin
      if (stat.scan_hit) begin
        hint     <= ptr;
        res_ok   <= 1'b1;
        res_addr <= hit_addr;
      end else begin
        ptr <= WPTR_W'(ptr_inc);
      end
    end
    if (ctl.free_start) free_frame <= f_in[FRAME_IDX_W-1:0];
    if (ctl.free_check && free_bit) begin
      res_ok <= 1'b1;
      if (WPTR_W'(free_word) < hint) hint <= WPTR_W'(free_word);
    end
    if (ctl.resp_load) begin
      alloc_addr     <= res_addr;
      ok             <= res_ok;
      free_frames    <= CNT_OUT_W'(free_total);
      managed_frames <= CNT_OUT_W'(frame_total);
    end
  end

`ifndef SYNTH
  // frame total is loaded the cycle before the free count during init
  a_free_le_total: assert property (@(posedge clk) disable iff (rst)
    !ctl.init_size |-> free_total <= frame_total)
    else $error("free count above frame total");

  a_alloc_dec: assert property (@(posedge clk) disable iff (rst)
    ctl.scan_check && stat.scan_hit |=> free_total == $past(free_total) - CNT_W'(1))
    else $error("allocation did not take one frame");

  a_scan_finds: assert property (@(posedge clk) disable iff (rst)
    ctl.scan_check && stat.scan_last |-> stat.scan_hit)
    else $error("scan ran off the map with frames still free");

  a_sweep_range: assert property (@(posedge clk) disable iff (rst)
    ctl.init_write |-> ptr < nwords)
    else $error("init sweep past managed words");

  a_resp_slot: assert property (@(posedge clk) disable iff (rst)
    ctl.resp_load |-> !stat.out_busy)
    else $error("result loaded over a pending word");
`endif

endmodule

// ----- hdl/bitmap_frame_allocator_top.sv -----
// Accept to out_valid: alloc scans bitmap words from a search hint, which keeps the
// scan near one word; free reads and rewrites its word; init sizes then sweeps
// ceil(total/32) words; a no-free alloc, out-of-range free or NOP goes to the result.
// Throughput: one command at a time; next word taken the cycle after the load.
// Reset (rst, synchronous): counters zero, config to defaults; the bitmap RAM
// needs no clearing pass, the init command sweeps it.
// ----------------------------------------------------------------------------
// bitmap_frame_allocator_top
// First-fit 4 KiB frame allocator with a one-bit-per-frame bitmap above 1 MiB.
// ----------------------------------------------------------------------------
module bitmap_frame_allocator_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wr_en,
  input  logic [1:0]                      cfg_index,
  input  logic [bfa_pkg::CFG_W-1:0]       cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      cmd,
  input  logic [bfa_pkg::ADDR_W-1:0]      frame_addr_in,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [bfa_pkg::ADDR_OUT_W-1:0]  alloc_addr,
  output logic                            ok,
  output logic [bfa_pkg::CNT_OUT_W-1:0]   free_frames,
  output logic [bfa_pkg::CNT_OUT_W-1:0]   managed_frames
);
  import bfa_pkg::*;

  dp_cmd_t  ctl;
  dp_stat_t stat;

  // Sequencer
  bfa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .stat     (stat),
    .ctl      (ctl)
  );

  // Bitmap, counters and output register
  bfa_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .frame_addr_in  (frame_addr_in),
    .ctl            (ctl),
    .stat           (stat),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .alloc_addr     (alloc_addr),
    .ok             (ok),
    .free_frames    (free_frames),
    .managed_frames (managed_frames)
  );

endmodule

// ----- sim/bitmap_frame_allocator_top_tb.sv -----
// ----------------------------------------------------------------------------
// bitmap_frame_allocator_top_tb
// Self-checking bench for the first-fit frame allocator. Commands go in over a
// valid/ready word channel from a backlog queue. A bitmap predictor in the
// bench computes each expected response, and the response port is checked
// field by field in order. Both sides stall at random. The run steps through
// several memory sizes and kernel sizes, from empty maps to the full bitmap.
// ----------------------------------------------------------------------------
module bitmap_frame_allocator_top_tb;
  import bfa_pkg::*;

  typedef struct packed {
    cmd_t                op;
    logic [ADDR_W-1:0]   addr;
  } frame_req_t;

  typedef struct packed {
    logic [ADDR_OUT_W-1:0] addr;
    logic                  ok;
    logic [CNT_OUT_W-1:0]  free_cnt;
    logic [CNT_OUT_W-1:0]  total;
  } frame_resp_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_wr_en = 1'b0;
  logic [1:0]            cfg_index = CFG_MEM_SIZE_VALID;
  logic [CFG_W-1:0]      cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [1:0]            cmd = CMD_NOP;
  logic [ADDR_W-1:0]     frame_addr_in = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [ADDR_OUT_W-1:0] alloc_addr;
  logic                  ok;
  logic [CNT_OUT_W-1:0]  free_frames;
  logic [CNT_OUT_W-1:0]  managed_frames;

  bitmap_frame_allocator_top dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state: used bitmap, counters and a copy of the registers
  logic [31:0]       frame_map [MAP_WORDS];
  int unsigned       map_free = 0;
  int unsigned       map_total = 0;
  bit                cfg_mem_valid = 1'b1;
  logic [KB_W-1:0]   cfg_kb = '0;
  logic [ADDR_W-1:0] cfg_kend = MEM_BASE;

  frame_req_t  cmd_backlog[$];
  frame_resp_t pending_results[$];
  frame_req_t  offered;
  int n_queued = 0, n_done = 0, n_errors = 0, n_phases = 1;
  int n_alloc_ok = 0, n_alloc_oom = 0, n_free_ok = 0, n_free_bad = 0, n_inits = 0;
  int cyc = 0;
  bit hold_req = 1'b0, hold_taken = 1'b0;
  int hold_left = 0;

  wire calm = (cyc >= 3000) && (cyc < 9000);

  always @(posedge clk) cyc <= cyc + 1;

  // First-fit allocator behavior on one command word
  function automatic frame_resp_t run_frame_cmd(frame_req_t rq);
    frame_resp_t r;
    int unsigned w, b, f, kfr, tot;
    bit found;
    r = '0;
    found = 1'b0;
    case (rq.op)
      CMD_ALLOC: begin
        for (w = 0; w * 32 < map_total && !found; w++) begin
          for (b = 0; b < 32 && !found; b++) begin
            f = w * 32 + b;
            if (f < map_total && !frame_map[w][b]) begin
              frame_map[w][b] = 1'b1;
              map_free--;
              r.addr = ADDR_OUT_W'(MEM_BASE + (f << FRAME_SHIFT));
              r.ok = 1'b1;
              found = 1'b1;
            end
          end
        end
      end
      CMD_FREE: begin
        if (rq.addr >= MEM_BASE) begin
          f = (rq.addr - MEM_BASE) >> FRAME_SHIFT;
          if (f < map_total && frame_map[f >> 5][f & 31]) begin
            frame_map[f >> 5][f & 31] = 1'b0;
            map_free++;
            r.ok = 1'b1;
          end
        end
      end
      CMD_INIT: begin
        // size from the reported memory, else the 15 MiB fallback
        tot = (cfg_mem_valid && cfg_kb != 0) ? (cfg_kb >> 2) : FALLBACK_FRAMES;
        if (tot > MAX_FRAME_COUNT) tot = MAX_FRAME_COUNT;
        foreach (frame_map[i]) frame_map[i] = '0;
        map_total = tot;
        // kernel frames; an end below 1 MiB wraps and reserves everything
        kfr = 32'(cfg_kend - MEM_BASE) >> FRAME_SHIFT;
        kfr = kfr + 1;
        if (kfr > tot) kfr = tot;
        for (f = 0; f < kfr; f++) frame_map[f >> 5][f & 31] = 1'b1;
        map_free = tot - kfr;
        r.ok = 1'b1;
      end
      default: ;
    endcase
    r.free_cnt = map_free[CNT_OUT_W-1:0];
    r.total = map_total[CNT_OUT_W-1:0];
    return r;
  endfunction

  // Command driver: offers backlog words, random gaps
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        pending_results.push_back(run_frame_cmd(offered));
        case (offered.op)
          CMD_ALLOC: if (pending_results[$].ok) n_alloc_ok++; else n_alloc_oom++;
          CMD_FREE:  if (pending_results[$].ok) n_free_ok++; else n_free_bad++;
          CMD_INIT:  n_inits++;
          default: ;
        endcase
      end
      if (!in_valid || in_ready) begin
        if (cmd_backlog.size() > 0 && (calm || $urandom_range(99) >= 27)) begin
          offered = cmd_backlog.pop_front();
          in_valid <= 1'b1;
          cmd <= offered.op;
          frame_addr_in <= offered.addr;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Response ready: random stalls plus one long hold-off
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (hold_req && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_left <= 400;
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(99) >= 27);
    end
  end

  task automatic report_bad(string what, frame_resp_t want, frame_resp_t got);
    n_errors++;
    if (n_errors <= 10) begin
      $display("ERROR %0d: %s exp addr=%h ok=%b free=%0d total=%0d",
               n_done, what, want.addr, want.ok, want.free_cnt, want.total);
      $display("          got addr=%h ok=%b free=%0d total=%0d",
               got.addr, got.ok, got.free_cnt, got.total);
    end
  endtask

  // Response checker
  always @(posedge clk) begin
    frame_resp_t got, want;
    if (!rst && out_valid && out_ready) begin
      got = '{alloc_addr, ok, free_frames, managed_frames};
      if (pending_results.size() == 0) begin
        report_bad("unexpected word", '0, got);
      end else begin
        want = pending_results.pop_front();
        if (got.addr !== want.addr || got.ok !== want.ok ||
            got.free_cnt !== want.free_cnt || got.total !== want.total)
          report_bad("field mismatch", want, got);
      end
      n_done++;
    end
  end

  task automatic push_cmd(cmd_t op, logic [ADDR_W-1:0] addr);
    cmd_backlog.push_back('{op, addr});
    n_queued++;
  endtask

  task automatic wait_drain();
    wait (n_done >= n_queued);
    @(posedge clk);
  endtask

  // Register writes back to back; only called with the block idle
  task automatic apply_setting(bit v, logic [KB_W-1:0] kb, logic [ADDR_W-1:0] kend);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_MEM_SIZE_VALID;
    cfg_wdata <= {31'b0, v};
    @(posedge clk);
    cfg_index <= CFG_UPPER_MEM_KB;
    cfg_wdata <= {10'b0, kb};
    @(posedge clk);
    cfg_index <= CFG_KERNEL_END_ADDR;
    cfg_wdata <= kend;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cfg_mem_valid = v;
    cfg_kb = kb;
    cfg_kend = kend;
    n_phases++;
  endtask

  // One setting: init, then mostly allocs and frees aimed at used frames
  task automatic run_phase(bit v, logic [KB_W-1:0] kb, logic [ADDR_W-1:0] kend,
                           int n, bit squeeze);
    int unsigned kres, nalloc, hi, f, pick, tot;
    wait_drain();
    apply_setting(v, kb, kend);
    push_cmd(CMD_INIT, $urandom);
    wait_drain();
    tot = map_total;
    kres = map_total - map_free;
    nalloc = 0;
    if (squeeze) hold_req = 1'b1;
    repeat (n) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        push_cmd(CMD_ALLOC, $urandom);
        nalloc++;
      end else if (pick < 85) begin
        hi = kres + nalloc + 2;
        f = $urandom_range(hi);
        push_cmd(CMD_FREE, MEM_BASE + (f << FRAME_SHIFT) + $urandom_range(4095));
      end else if (pick < 88) begin
        push_cmd(CMD_FREE, $urandom);
      end else if (pick < 90) begin
        // last frame in range and first one past it
        f = tot - $urandom_range(1);
        push_cmd(CMD_FREE, MEM_BASE + (f << FRAME_SHIFT));
      end else if (pick < 94) begin
        push_cmd(CMD_FREE, $urandom_range(32'h000F_FFFF));
      end else if (pick < 97) begin
        push_cmd(CMD_NOP, $urandom);
      end else begin
        push_cmd(CMD_INIT, $urandom);
      end
    end
  endtask

  initial begin
    foreach (frame_map[i]) frame_map[i] = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: before init, fallback sizing, kernel frame, rounding, range
    push_cmd(CMD_ALLOC, 32'h0);
    push_cmd(CMD_FREE, MEM_BASE);
    push_cmd(CMD_INIT, 32'hFFFF_FFFF);
    push_cmd(CMD_ALLOC, 32'h0);
    push_cmd(CMD_ALLOC, 32'h0);
    push_cmd(CMD_FREE, 32'h0010_1ABC);
    push_cmd(CMD_FREE, 32'h0010_1000);
    push_cmd(CMD_FREE, 32'h000F_FFFF);
    push_cmd(CMD_FREE, 32'hFFFF_FFFF);
    push_cmd(CMD_FREE, 32'h0010_0FFF);
    push_cmd(CMD_NOP, 32'hA5A5_5A5A);
    push_cmd(CMD_ALLOC, 32'h0);
    push_cmd(CMD_ALLOC, 32'h0);
    push_cmd(CMD_FREE, MEM_BASE + (3839 << FRAME_SHIFT));
    push_cmd(CMD_FREE, MEM_BASE + (3840 << FRAME_SHIFT));
    push_cmd(CMD_ALLOC, 32'h0);
    push_cmd(CMD_FREE, MEM_BASE + (3 << FRAME_SHIFT));
    push_cmd(CMD_INIT, 32'h0);

    // Settings: full bitmap, fallback, empty map, all reserved, small maps
    run_phase(1'b1, 22'h3F_FFFF, MEM_BASE, 25, 1'b0);
    run_phase(1'b0, 22'd300, MEM_BASE, 80, 1'b1);
    run_phase(1'b1, 22'd2, MEM_BASE, 30, 1'b0);
    run_phase(1'b1, 22'd128, 32'hFFFF_FFFF, 30, 1'b0);
    run_phase(1'b1, 22'd160, 32'h0010_4FFF, 100, 1'b0);
    run_phase(1'b1, 22'd0, MEM_BASE + (3830 << FRAME_SHIFT), 60, 1'b0);
    run_phase(1'b1, 22'h3F_FFFF, 32'hFFFF_FFFF, 20, 1'b0);
    while (n_queued < 1300) begin
      run_phase($urandom_range(9) != 0,
                ($urandom_range(3) == 0) ? 22'($urandom) : 22'($urandom_range(640, 16)),
                ($urandom_range(3) == 0) ? $urandom_range(32'hFFFF_FFFF, MEM_BASE) :
                  MEM_BASE + ($urandom_range(40) << FRAME_SHIFT) + $urandom_range(4095),
                $urandom_range(140, 60), 1'b0);
    end

    wait_drain();
    repeat (1100) @(posedge clk);
    n_errors += pending_results.size();
    $display("Ran %0d command words over %0d settings, %0d map inits.",
             n_queued, n_phases, n_inits);
    $display("Allocs: %0d granted, %0d out of memory; frees: %0d released, %0d ignored.",
             n_alloc_ok, n_alloc_oom, n_free_ok, n_free_bad);
    if (n_errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #100_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/bfa_pkg.sv
hdl/bfa_ctrl.sv
hdl/bfa_dp.sv
hdl/bitmap_frame_allocator_top.sv
sim/bitmap_frame_allocator_top_tb.sv
